### hw/rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int ROWS = 25;
    localparam int COLS = 80;
    localparam int DEPTH = ROWS * COLS;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = 5;
    localparam int CW = 7;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_location;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_RESULT,
        ST_FILL,
        ST_SCROLL
    } back_state_t;

endpackage

### hw/rtl/tcw_front.sv
module tcw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tcw_pkg::in_item_t in_item,
    output logic              q_valid,
    input  logic              q_take,
    output tcw_pkg::in_item_t q_item
);
    import tcw_pkg::*;

    in_item_t   buf_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = buf_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            buf_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_take && q_valid)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, q_take && q_valid};
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !(q_take && q_valid) |=> full)
        else $error("queue lost an entry");
    a_empty_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid && !push |=> !q_valid)
        else $error("queue invented an entry");

endmodule

### hw/rtl/tcw_back.sv
module tcw_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_take,
    input  tcw_pkg::in_item_t  q_item,
    input  logic [7:0]         scroll_attr,
    output logic               busy,
    output logic               empty,
    input  logic               pop,
    output tcw_pkg::out_item_t out_item
);
    import tcw_pkg::*;

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    back_state_t st_reg, st_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] top_reg, top_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   fill_reg, fill_next;
    logic          init_reg, init_next;
    logic          is_read_reg, is_read_next;
    logic          ovalid_reg;
    out_item_t     out_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic [AW-1:0] raddr;
    logic          take;
    logic          done;

    logic [RW:0]   prow_sum;
    logic [RW-1:0] prow;
    logic [AW-1:0] cur_base;
    logic [RW:0]   rrow_sum;
    logic [RW-1:0] rprow;
    logic [RW:0]   nrow;
    logic [CW:0]   ncol;
    logic [RW:0]   top_inc;
    logic [RW-1:0] bot_prow;

    assign take  = (st_reg == ST_IDLE) && q_valid && !init_reg;
    assign q_take = take;
    assign busy  = (st_reg != ST_IDLE) || init_reg;
    assign empty = !ovalid_reg;
    assign out_item = out_reg;

    assign prow_sum = {1'b0, top_reg} + {1'b0, row_reg};
    assign prow     = (prow_sum >= (RW+1)'(ROWS)) ? RW'(prow_sum - (RW+1)'(ROWS))
                                                   : RW'(prow_sum);
    assign cur_base = AW'(prow) * AW'(COLS);
    assign rrow_sum = {1'b0, top_reg} + {1'b0, q_item.read_row};
    assign rprow    = (rrow_sum >= (RW+1)'(ROWS)) ? RW'(rrow_sum - (RW+1)'(ROWS))
                                                   : RW'(rrow_sum);
    assign raddr    = AW'(rprow) * AW'(COLS) + AW'(q_item.read_col);
    assign top_inc  = {1'b0, top_reg} + (RW+1)'(1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (take)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        st_next      = st_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        top_next     = top_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        fill_next    = fill_reg;
        init_next    = init_reg;
        is_read_next = is_read_reg;
        we           = 1'b0;
        waddr        = ptr_reg;
        wdata        = fill_reg;
        done         = 1'b0;
        nrow         = {1'b0, row_reg};
        ncol         = {1'b0, col_reg};
        bot_prow     = '0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (init_reg)
                begin
                    we       = 1'b1;
                    ptr_next = ptr_reg + AW'(1);
                    if (ptr_reg == AW'(DEPTH - 1))
                    begin
                        init_next = 1'b0;
                    end
                end
                else if (take)
                begin
                    is_read_next = 1'b0;
                    unique case (q_item.func)
                        FUNC_PUT:
                        begin
                            if (q_item.char_code == CH_BS)
                            begin
                                if (col_reg != '0)
                                begin
                                    we    = 1'b1;
                                    waddr = cur_base + AW'(col_reg) - AW'(1);
                                    wdata = {q_item.attribute, CH_SPACE};
                                    ncol  = {1'b0, col_reg} - (CW+1)'(1);
                                end
                            end
                            else if (q_item.char_code == CH_CR)
                            begin
                                ncol = '0;
                            end
                            else if (q_item.char_code == CH_LF)
                            begin
                                nrow = {1'b0, row_reg} + (RW+1)'(1);
                                ncol = '0;
                            end
                            else if (q_item.char_code == CH_TAB)
                            begin
                                ncol = ({1'b0, col_reg} + (CW+1)'(4)) & ~(CW+1)'(3);
                            end
                            else if (q_item.char_code >= CH_SPACE)
                            begin
                                we    = 1'b1;
                                waddr = cur_base + AW'(col_reg);
                                wdata = {q_item.attribute, q_item.char_code};
                                ncol  = {1'b0, col_reg} + (CW+1)'(1);
                            end
                            if (ncol >= (CW+1)'(COLS))
                            begin
                                nrow = nrow + (RW+1)'(1);
                                ncol = '0;
                            end
                            col_next = CW'(ncol);
                            if (nrow >= (RW+1)'(ROWS))
                            begin
                                row_next = RW'(ROWS - 1);
                                top_next = (top_inc >= (RW+1)'(ROWS)) ? '0 : RW'(top_inc);
                                bot_prow = top_reg;
                                ptr_next = AW'(bot_prow) * AW'(COLS);
                                cnt_next = '0;
                                fill_next = {scroll_attr, CH_SPACE};
                                st_next  = ST_SCROLL;
                            end
                            else
                            begin
                                row_next = RW'(nrow);
                                st_next  = ST_RESULT;
                            end
                        end
                        FUNC_READ:
                        begin
                            is_read_next = (q_item.read_row < RW'(ROWS))
                                        && (q_item.read_col < CW'(COLS));
                            st_next = ST_READ;
                        end
                        FUNC_CLEAR:
                        begin
                            row_next  = '0;
                            col_next  = '0;
                            top_next  = '0;
                            ptr_next  = '0;
                            fill_next = {q_item.attribute, CH_SPACE};
                            st_next   = ST_FILL;
                        end
                        default:
                        begin
                            st_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                st_next = ST_RESULT;
            end
            ST_FILL:
            begin
                we       = 1'b1;
                ptr_next = ptr_reg + AW'(1);
                if (ptr_reg == AW'(DEPTH - 1))
                begin
                    st_next = ST_RESULT;
                end
            end
            ST_SCROLL:
            begin
                we       = 1'b1;
                ptr_next = ptr_reg + AW'(1);
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(COLS - 1))
                begin
                    st_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!ovalid_reg || pop)
                begin
                    done    = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            top_reg     <= '0;
            ptr_reg     <= '0;
            cnt_reg     <= '0;
            fill_reg    <= '0;
            init_reg    <= 1'b1;
            is_read_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            top_reg     <= top_next;
            ptr_reg     <= ptr_next;
            cnt_reg     <= cnt_next;
            fill_reg    <= fill_next;
            init_reg    <= init_next;
            is_read_reg <= is_read_next;
            if (done)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg.cell_data       <= is_read_reg ? rdata_reg : 16'h0000;
            out_reg.cursor_row      <= row_reg;
            out_reg.cursor_col      <= col_reg;
            out_reg.cursor_location <= 11'(AW'(row_reg) * AW'(COLS) + AW'(col_reg));
        end
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !ovalid_reg || st_reg == ST_IDLE)
        else $error("take outside idle");
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !ovalid_reg || pop)
        else $error("result overwritten");
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < RW'(ROWS) && col_reg < CW'(COLS) && top_reg < RW'(ROWS))
        else $error("cursor out of range");
    a_no_take_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !take)
        else $error("item taken during clearing pass");

endmodule

### hw/rtl/text_console_writer_core.sv
// Text-mode console engine.
// Input channel: push/full carries one transaction (func, char_code,
// attribute, read_row, read_col); it is taken when push is high and full low.
// Result channel: empty/pop; one result per transaction, in order, with the
// cell read (zero unless a valid read) and the cursor after the transaction.
// Configuration: cfg_valid/cfg_ready write scroll_attribute (reset 7); ready
// is high only while the engine is idle.
// A two-entry queue decouples intake from the engine. Ordinary characters,
// control codes and reads end in ST_RESULT, reads by way of ST_READ; a scroll
// first blanks a row of COLS (80) cells and a clear walks all ROWS*COLS (2000)
// cells, one per cycle, through the single write port of the cell memory.
// After reset the engine runs a clearing pass over every cell to zero the
// screen; transactions queue meanwhile but are not processed.
// When the receiver stalls, one finished result waits in the output
// register, the engine holds the next, and the queue fills to assert full.
module text_console_writer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tcw_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output tcw_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import tcw_pkg::*;

    logic       q_valid;
    logic       q_take;
    in_item_t   q_item;
    logic       busy;
    logic [7:0] scroll_attr_reg;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_attr_reg <= 8'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scroll_attr_reg <= cfg_data;
        end
    end

    tcw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    tcw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_take      (q_take),
        .q_item      (q_item),
        .scroll_attr (scroll_attr_reg),
        .busy        (busy),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item)
    );

endmodule

### tb/text_console_writer_core_tb.sv
`timescale 1ns / 1ps

module text_console_writer_core_tb;
    import tcw_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_CFG,
        ACT_SETTLE,
        ACT_HOLD
    } act_kind_e;

    typedef struct {
        act_kind_e kind;
        in_item_t  item;
        logic [7:0] cfg;
        int        gap;
    } action_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  in_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [7:0] cfg_data = '0;

    action_t   pending[$];
    out_item_t expected_results[$];
    logic      in_taken = 1'b0;
    logic      cfg_taken = 1'b0;
    logic      out_taken = 1'b0;
    int        errors = 0;
    int        gap_left = 0;
    int        settle_cnt = 0;
    int        hold_seq = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        stall_left = 0;

    logic [15:0] screen[DEPTH];
    int          cur_row = 0;
    int          cur_col = 0;
    int          top_row = 0;
    logic [7:0]  scroll_attr = 8'd7;

    text_console_writer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int cell_addr(int row, int col);
        return ((top_row + row) % ROWS) * COLS + col;
    endfunction

    function automatic out_item_t console_step(in_item_t it);
        out_item_t res;
        res = '0;
        case (it.func)
            FUNC_PUT:
            begin
                if (it.char_code == CH_BS) begin
                    if (cur_col > 0) begin
                        screen[cell_addr(cur_row, cur_col - 1)] = {it.attribute, CH_SPACE};
                        cur_col--;
                    end
                end else if (it.char_code == CH_CR) begin
                    cur_col = 0;
                end else if (it.char_code == CH_LF) begin
                    cur_row++;
                    cur_col = 0;
                end else if (it.char_code == CH_TAB) begin
                    cur_col = (cur_col + 4) & ~3;
                end else if (it.char_code >= CH_SPACE) begin
                    screen[cell_addr(cur_row, cur_col)] = {it.attribute, it.char_code};
                    cur_col++;
                end
                if (cur_col >= COLS) begin
                    cur_row++;
                    cur_col = 0;
                end
                if (cur_row >= ROWS) begin
                    top_row = (top_row + 1) % ROWS;
                    for (int c = 0; c < COLS; c++)
                        screen[cell_addr(ROWS - 1, c)] = {scroll_attr, CH_SPACE};
                    cur_row = ROWS - 1;
                end
            end
            FUNC_READ:
            begin
                if (it.read_row < ROWS && it.read_col < COLS)
                    res.cell_data = screen[cell_addr(it.read_row, it.read_col)];
            end
            FUNC_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                    screen[i] = {it.attribute, CH_SPACE};
                cur_row = 0;
                cur_col = 0;
                top_row = 0;
            end
            default:
            begin
            end
        endcase
        res.cursor_row = cur_row[4:0];
        res.cursor_col = cur_col[6:0];
        res.cursor_location = 11'(cur_row * COLS + cur_col);
        return res;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        out_item_t exp_r;
        if (rst_n) begin
            in_taken  <= push && !full;
            cfg_taken <= cfg_valid && cfg_ready;
            out_taken <= pop && !empty;
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %0h", $time, out_item);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("cell_data", exp_r.cell_data, out_item.cell_data);
                    check_field("cursor_row", exp_r.cursor_row, out_item.cursor_row);
                    check_field("cursor_col", exp_r.cursor_col, out_item.cursor_col);
                    check_field("cursor_location", exp_r.cursor_location,
                                out_item.cursor_location);
                end
            end
            if (push && !full)
                expected_results.push_back(console_step(in_item));
            if (cfg_valid && cfg_ready)
                scroll_attr = cfg_data;
        end
    end

    always @(negedge clk) begin
        logic nxt_push;
        logic nxt_cfg;
        action_t act;
        if (rst_n) begin
            nxt_push = push && !in_taken;
            nxt_cfg = cfg_valid && !cfg_taken;
            if (!nxt_push && !nxt_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0) begin
                    act = pending[0];
                    case (act.kind)
                        ACT_ITEM:
                        begin
                            in_item <= act.item;
                            nxt_push = 1'b1;
                            gap_left = act.gap;
                            void'(pending.pop_front());
                        end
                        ACT_CFG:
                        begin
                            cfg_data <= act.cfg;
                            nxt_cfg = 1'b1;
                            void'(pending.pop_front());
                        end
                        ACT_SETTLE:
                        begin
                            if (expected_results.size() == 0)
                                settle_cnt++;
                            if (settle_cnt >= 4) begin
                                settle_cnt = 0;
                                void'(pending.pop_front());
                            end
                        end
                        default:
                        begin
                            hold_seq++;
                            void'(pending.pop_front());
                        end
                    endcase
                end
            end
            push <= nxt_push;
            cfg_valid <= nxt_cfg;
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (out_taken && stall_left == 0)
                stall_left = pick_gap();
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_item(logic [1:0] func, logic [7:0] ch, logic [7:0] attr,
                            logic [4:0] row, logic [6:0] col, int gap);
        action_t act;
        act.kind = ACT_ITEM;
        act.item = '{func, ch, attr, row, col};
        act.cfg = '0;
        act.gap = gap;
        pending.push_back(act);
    endtask

    task automatic add_ctrl(act_kind_e kind, logic [7:0] value);
        action_t act;
        act.kind = kind;
        act.item = '0;
        act.cfg = value;
        act.gap = 0;
        pending.push_back(act);
    endtask

    task automatic add_random(bit no_gaps);
        in_item_t it;
        int r;
        it = in_item_t'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55) begin
            it.func = FUNC_PUT;
            it.char_code = 8'($urandom_range(32, 255));
        end else if (r < 68) begin
            it.func = FUNC_PUT;
            case ($urandom_range(0, 4))
                0: it.char_code = CH_BS;
                1: it.char_code = CH_TAB;
                2: it.char_code = CH_LF;
                3: it.char_code = CH_CR;
                default: it.char_code = 8'($urandom_range(0, 31));
            endcase
        end else if (r < 92) begin
            it.func = FUNC_READ;
            if ($urandom_range(0, 4) != 0) begin
                it.read_row = 5'($urandom_range(0, ROWS - 1));
                it.read_col = 7'($urandom_range(0, COLS - 1));
            end
        end else if (r < 94) begin
            it.func = FUNC_CLEAR;
        end else if (r < 96) begin
            it.func = FUNC_NONE;
        end else begin
            it.func = FUNC_PUT;
        end
        add_item(it.func, it.char_code, it.attribute, it.read_row, it.read_col,
                 no_gaps ? 0 : pick_gap());
    endtask

    initial begin
        logic [7:0] phase_attr[5];
        phase_attr = '{8'h00, 8'hFF, 8'($urandom), 8'h80, 8'h07};
        foreach (screen[i])
            screen[i] = '0;

        add_item(FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd0, 0);
        add_item(FUNC_PUT, CH_BS, 8'h11, 5'd0, 7'd0, 0);
        add_item(FUNC_PUT, 8'h00, 8'h00, 5'd0, 7'd0, 0);
        add_item(FUNC_PUT, 8'h1F, 8'hFF, 5'd0, 7'd0, 0);
        add_item(FUNC_PUT, CH_SPACE, 8'h00, 5'd0, 7'd0, 0);
        add_item(FUNC_PUT, 8'hFF, 8'hFF, 5'd0, 7'd0, 0);
        add_item(FUNC_PUT, CH_TAB, 8'h00, 5'd0, 7'd0, 1);
        add_item(FUNC_PUT, 8'h41, 8'h5A, 5'd0, 7'd0, 0);
        add_item(FUNC_PUT, CH_BS, 8'hA5, 5'd0, 7'd0, 0);
        add_item(FUNC_PUT, CH_CR, 8'h00, 5'd0, 7'd0, 0);
        add_item(FUNC_PUT, CH_LF, 8'h00, 5'd0, 7'd0, 2);
        add_item(FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd0, 0);
        add_item(FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd4, 0);
        add_item(FUNC_READ, 8'h00, 8'h00, 5'd24, 7'd79, 0);
        add_item(FUNC_READ, 8'hFF, 8'hFF, 5'd25, 7'd0, 0);
        add_item(FUNC_READ, 8'h00, 8'h00, 5'd0, 7'd80, 0);
        add_item(FUNC_READ, 8'h00, 8'h00, 5'd31, 7'd127, 0);
        add_item(FUNC_NONE, 8'hFF, 8'hFF, 5'd31, 7'd127, 0);
        add_item(FUNC_CLEAR, 8'h00, 8'hFF, 5'd0, 7'd0, 0);
        add_item(FUNC_READ, 8'h00, 8'h00, 5'd12, 7'd40, 0);
        add_item(FUNC_CLEAR, 8'hFF, 8'h00, 5'd31, 7'd127, 0);

        for (int p = 0; p < 5; p++) begin
            add_ctrl(ACT_SETTLE, 8'h00);
            add_ctrl(ACT_CFG, phase_attr[p]);
            if (p == 2)
                add_ctrl(ACT_HOLD, 8'h00);
            for (int i = 0; i < 375; i++) begin
                if (i == 180)
                    add_ctrl(ACT_SETTLE, 8'h00);
                add_random(p == 2 || p == 3);
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending.size() == 0 && !push && !cfg_valid && expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_core.sv
tb/text_console_writer_core_tb.sv
